[sv/ssa_pkg.sv]
// shared types and codes for the swap slot allocator
// no dependencies; imported by swap_slot_allocator
package ssa_pkg;

    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int SECTOR_W = 13;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_RANGE  = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

[sv/swap_slot_allocator.sv]
// swap slot allocator: lifo free stack plus bump pointer, with a free-mark bitmap
// depends on ssa_pkg; holds the free stack and the mark bitmap as local memories
//
//   channel   handshake                  payload
//   command   i_start / o_busy           i_action, i_slot
//   result    o_done (one-cycle strobe)  o_status, o_slot_out, o_first_sector, o_was_free
//   config    i_cfg_valid / o_cfg_ready  i_cfg_data (last_slot)
//
// each command passes idle then exec: the accepting edge in idle reads the stack top and the
// slot's mark bit, the exec edge modifies and writes them back and registers the result.
// the result strobe shows in the cycle after that, when a new command can already enter.
// reset sets the state, the pointers, the done strobe and last_slot only; the bitmap is
// written at every bump allocation, so entries below the high-water mark are always valid
// and no clearing pass is needed. the receiver cannot stall, so results never back up.
module swap_slot_allocator #(
    parameter int SLOTS            = 1024,
    parameter int SECTORS_PER_SLOT = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [ssa_pkg::ACTION_W-1:0]  i_action,
    input  logic [ssa_pkg::SLOT_W-1:0]    i_slot,
    output logic                          o_done,
    output logic [ssa_pkg::STATUS_W-1:0]  o_status,
    output logic [ssa_pkg::SLOT_W-1:0]    o_slot_out,
    output logic [ssa_pkg::SECTOR_W-1:0]  o_first_sector,
    output logic                          o_was_free,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ssa_pkg::SLOT_W-1:0]    i_cfg_data
);
    import ssa_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;
    localparam int CW = XW + 1;
    localparam int PR = SLOT_W + $clog2(SECTORS_PER_SLOT + 1);
    localparam int PW = (PR > SECTOR_W) ? PR : SECTOR_W;
    localparam logic [CW-1:0] LAST_IDX = CW'(SLOTS - 1);
    localparam logic [AW:0]   DEPTH_MAX = (AW + 1)'(SLOTS);

    logic [AW-1:0] mem_stack [SLOTS];
    logic          mem_mark  [SLOTS];

    t_state r_state, n_state;
    logic [SLOT_W-1:0]   r_last_slot;
    logic [AW:0]         r_hw, n_hw;
    logic [AW:0]         r_depth, n_depth;
    logic [ACTION_W-1:0] r_action;
    logic [SLOT_W-1:0]   r_slot;
    logic [AW-1:0]       r_stack_q;
    logic                r_mark_q;
    logic                r_done, n_done;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SLOT_W-1:0]   r_slot_out, n_slot_out;
    logic                r_was_free, n_was_free;

    logic          accept;
    logic [AW:0]   depth_m1;
    logic [XW-1:0] mark_ra_x;
    logic [AW-1:0] stack_ra, mark_ra;
    logic          stack_we, mark_we, mark_wd;
    logic [AW-1:0] stack_wa, mark_wa;
    logic [CW-1:0] lim, slot_x, hw_x;
    logic          slot_free;
    logic [PW-1:0] sector_prod;

    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // mark read address comes from the command, stack read address from the current depth
    assign depth_m1  = r_depth - 1'b1;
    assign stack_ra  = depth_m1[AW-1:0];
    assign mark_ra_x = XW'(i_slot);
    assign mark_ra   = mark_ra_x[AW-1:0];

    // effective limit is the smaller of last_slot and the top slot index
    always_comb begin
        lim = (CW'(r_last_slot) > LAST_IDX) ? LAST_IDX : CW'(r_last_slot);
    end

    assign slot_x    = CW'(r_slot);
    assign hw_x      = CW'(r_hw);
    assign slot_free = (slot_x >= hw_x) || r_mark_q;

    always_comb begin
        n_state    = r_state;
        n_hw       = r_hw;
        n_depth    = r_depth;
        n_done     = 1'b0;
        n_status   = r_status;
        n_slot_out = r_slot_out;
        n_was_free = r_was_free;
        stack_we   = 1'b0;
        stack_wa   = r_depth[AW-1:0];
        mark_we    = 1'b0;
        mark_wa    = slot_x[AW-1:0];
        mark_wd    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (r_action == ACT_ALLOC) begin
                    if (r_depth != '0 && r_depth <= DEPTH_MAX) begin
                        n_depth    = depth_m1;
                        mark_we    = 1'b1;
                        mark_wa    = r_stack_q;
                        mark_wd    = 1'b0;
                        n_status   = ST_OK;
                        n_slot_out = SLOT_W'(XW'(r_stack_q));
                        n_was_free = 1'b1;
                    end else if (hw_x <= lim) begin
                        // bump allocation also fills the bitmap entry
                        n_hw       = r_hw + 1'b1;
                        mark_we    = 1'b1;
                        mark_wa    = r_hw[AW-1:0];
                        mark_wd    = 1'b0;
                        n_status   = ST_OK;
                        n_slot_out = SLOT_W'(XW'(r_hw[AW-1:0]));
                        n_was_free = 1'b1;
                    end else begin
                        n_status   = ST_NO_SLOT;
                        n_slot_out = '0;
                        n_was_free = 1'b0;
                    end
                end else if (slot_x > lim) begin
                    n_status   = ST_OUT_RANGE;
                    n_slot_out = r_slot;
                    n_was_free = 1'b0;
                end else begin
                    n_slot_out = r_slot;
                    case (r_action)
                        ACT_RELEASE: begin
                            if (slot_free) begin
                                n_status   = ST_ALREADY;
                                n_was_free = 1'b1;
                            end else if (r_depth >= DEPTH_MAX) begin
                                n_status   = ST_NO_SLOT;
                                n_was_free = 1'b0;
                            end else begin
                                stack_we   = 1'b1;
                                n_depth    = r_depth + 1'b1;
                                mark_we    = 1'b1;
                                mark_wd    = 1'b1;
                                n_status   = ST_OK;
                                n_was_free = 1'b0;
                            end
                        end
                        ACT_READ: begin
                            n_status   = slot_free ? ST_ALREADY : ST_OK;
                            n_was_free = slot_free;
                        end
                        default: begin
                            n_status   = ST_OK;
                            n_was_free = slot_free;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_slot <= '1;
            r_hw        <= '0;
            r_depth     <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hw    <= n_hw;
            r_depth <= n_depth;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                r_last_slot <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_slot   <= i_slot;
        end
        r_status   <= n_status;
        r_slot_out <= n_slot_out;
        r_was_free <= n_was_free;
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            mem_stack[stack_wa] <= slot_x[AW-1:0];
        end
        if (accept) begin
            r_stack_q <= mem_stack[stack_ra];
        end
    end

    // free-mark bitmap memory
    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mem_mark[mark_wa] <= mark_wd;
        end
        if (accept) begin
            r_mark_q <= mem_mark[mark_ra];
        end
    end

    assign sector_prod    = PW'(r_slot_out) * PW'(SECTORS_PER_SLOT);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_slot_out     = r_slot_out;
    assign o_first_sector = sector_prod[SECTOR_W-1:0];
    assign o_was_free     = r_was_free;

endmodule
